>>> design/dq_pkg.sv
package dq_pkg;

  localparam int unsigned DEPTH  = 128;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned FAN_IN = 16;

  typedef enum logic [1:0] {
    MODE_PUSH_FRONT = 2'd0,
    MODE_PUSH_REAR  = 2'd1,
    MODE_POP_FRONT  = 2'd2,
    MODE_POP_REAR   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_SHIFT_UP,
    CELL_SHIFT_DN,
    CELL_PUSH_REAR,
    CELL_DROP_REAR
  } cell_op_e;

  typedef enum logic {
    ST_IDLE,
    ST_REAR_WAIT
  } state_e;

  typedef struct packed {
    cell_op_e            op;
    logic [WORD_W-1:0]   value;
  } cell_cmd_t;

  // registered OR-tree levels needed to reduce n taps to one
  function automatic int unsigned tree_levels(input int unsigned n);
    int unsigned cnt;
    int unsigned lvl;
    cnt = n;
    lvl = 0;
    while (cnt > 1) begin
      cnt = (cnt + FAN_IN - 1) / FAN_IN;
      lvl = lvl + 1;
    end
    if (lvl == 0) begin
      lvl = 1;
    end
    return lvl;
  endfunction

endpackage

>>> design/dq_ifs.sv
interface dq_in_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        mode;
  logic signed [dq_pkg::WORD_W-1:0]  push_value;

  modport source (output valid, output mode, output push_value, input ready);
  modport sink   (input valid, input mode, input push_value, output ready);
endinterface

interface dq_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [dq_pkg::WORD_W-1:0]  pop_value;
  logic [1:0]                        status;
  logic                              now_empty;
  logic                              now_full;

  modport source (output valid, output pop_value, output status, output now_empty,
                  output now_full, input ready);
  modport sink   (input valid, input pop_value, input status, input now_empty,
                  input now_full, output ready);
endinterface

>>> design/circular_deque_top.sv
// Double-ended queue of DEPTH signed 32-bit entries, built as a row of shift cells:
// cell 0 is always the front, and the occupied cells form one run from cell 0.
// Each operation (push front, push rear, pop front, pop rear) gives exactly one
// result with the popped value (-1 on a refused pop, 0 on any push), a status
// code (done, push dropped because full, pop refused because empty) and the
// empty and full flags after the operation. For push front, push rear, pop front
// and any refused operation, the item is taken and its result sits in the output
// register on the next cycle. A successful pop rear waits in ST_REAR_WAIT until
// the registered OR tree of fan-in 16 has picked out the last occupied cell, and
// then loads that cell's value into the output register. The input is taken only
// while the output register is empty or being drained in the same cycle.
module circular_deque_top #(
  parameter int unsigned DEPTH = dq_pkg::DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dq_in_if.sink       in_i,
  dq_out_if.source    out_o
);

  localparam int unsigned LEVELS = dq_pkg::tree_levels(DEPTH);
  localparam int unsigned WAIT_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  dq_pkg::state_e     state_q, state_d;
  logic [WAIT_W-1:0]  wait_q, wait_d;
  dq_pkg::cell_cmd_t  cmd;

  logic [dq_pkg::WORD_W-1:0] cell_val [DEPTH];
  logic                      cell_occ [DEPTH];
  logic [dq_pkg::WORD_W-1:0] cell_tap [DEPTH];
  logic [dq_pkg::WORD_W-1:0] rear_val;

  logic                      in_ready;
  logic                      load;
  logic [dq_pkg::WORD_W-1:0] pop_d;
  dq_pkg::status_e           status_d;
  logic                      empty_d, full_d;

  logic                      out_valid_q;
  logic [dq_pkg::WORD_W-1:0] pop_q;
  dq_pkg::status_e           status_q;
  logic                      empty_q, full_q;

  logic is_empty, is_full;
  assign is_empty = !cell_occ[0];
  assign is_full  = cell_occ[DEPTH-1];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [dq_pkg::WORD_W-1:0] prev_val, next_val;
    logic                      prev_occ, next_occ;

    if (i == 0) begin : g_first
      assign prev_val = in_i.push_value;
      assign prev_occ = 1'b1;
    end else begin : g_mid_prev
      assign prev_val = cell_val[i-1];
      assign prev_occ = cell_occ[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_val = '0;
      assign next_occ = 1'b0;
    end else begin : g_mid_next
      assign next_val = cell_val[i+1];
      assign next_occ = cell_occ[i+1];
    end

    dq_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cmd),
      .prev_val_i (prev_val),
      .prev_occ_i (prev_occ),
      .next_val_i (next_val),
      .next_occ_i (next_occ),
      .val_o      (cell_val[i]),
      .occ_o      (cell_occ[i]),
      .tap_o      (cell_tap[i])
    );
  end

  dq_rtree #(
    .N (DEPTH),
    .W (dq_pkg::WORD_W)
  ) u_rtree (
    .clk_i (clk_i),
    .tap_i (cell_tap),
    .sel_o (rear_val)
  );

  assign in_ready = (state_q == dq_pkg::ST_IDLE) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d   = state_q;
    wait_d    = wait_q;
    cmd.op    = dq_pkg::CELL_HOLD;
    cmd.value = in_i.push_value;
    load      = 1'b0;
    pop_d     = '0;
    status_d  = dq_pkg::STATUS_DONE;
    empty_d   = 1'b0;
    full_d    = 1'b0;
    case (state_q)
      dq_pkg::ST_IDLE: begin
        if (in_i.valid && in_ready) begin
          case (dq_pkg::mode_e'(in_i.mode))
            dq_pkg::MODE_PUSH_FRONT, dq_pkg::MODE_PUSH_REAR: begin
              load = 1'b1;
              if (is_full) begin
                status_d = dq_pkg::STATUS_FULL;
                full_d   = 1'b1;
              end else begin
                cmd.op = (dq_pkg::mode_e'(in_i.mode) == dq_pkg::MODE_PUSH_FRONT) ?
                         dq_pkg::CELL_SHIFT_UP : dq_pkg::CELL_PUSH_REAR;
                full_d = cell_occ[DEPTH-2];
              end
            end
            dq_pkg::MODE_POP_FRONT: begin
              load = 1'b1;
              if (is_empty) begin
                pop_d    = '1;
                status_d = dq_pkg::STATUS_EMPTY;
                empty_d  = 1'b1;
              end else begin
                cmd.op  = dq_pkg::CELL_SHIFT_DN;
                pop_d   = cell_val[0];
                empty_d = !cell_occ[1];
              end
            end
            dq_pkg::MODE_POP_REAR: begin
              if (is_empty) begin
                load     = 1'b1;
                pop_d    = '1;
                status_d = dq_pkg::STATUS_EMPTY;
                empty_d  = 1'b1;
              end else begin
                // wait in ST_REAR_WAIT until the tree output has settled
                state_d = dq_pkg::ST_REAR_WAIT;
                wait_d  = WAIT_W'(LEVELS - 1);
              end
            end
            default: ;
          endcase
        end
      end
      dq_pkg::ST_REAR_WAIT: begin
        if (wait_q == '0) begin
          load    = 1'b1;
          pop_d   = rear_val;
          empty_d = !cell_occ[1];
          cmd.op  = dq_pkg::CELL_DROP_REAR;
          state_d = dq_pkg::ST_IDLE;
        end else begin
          wait_d = wait_q - 1'b1;
        end
      end
      default: state_d = dq_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dq_pkg::ST_IDLE;
      wait_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      wait_q  <= wait_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      pop_q    <= pop_d;
      status_q <= status_d;
      empty_q  <= empty_d;
      full_q   <= full_d;
    end
  end

  assign in_i.ready      = in_ready;
  assign out_o.valid     = out_valid_q;
  assign out_o.pop_value = $signed(pop_q);
  assign out_o.status    = status_q;
  assign out_o.now_empty = empty_q;
  assign out_o.now_full  = full_q;

endmodule

>>> design/dq_cell.sv
module dq_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dq_pkg::cell_cmd_t             cmd_i,
  input  logic [dq_pkg::WORD_W-1:0]     prev_val_i,
  input  logic                          prev_occ_i,
  input  logic [dq_pkg::WORD_W-1:0]     next_val_i,
  input  logic                          next_occ_i,
  output logic [dq_pkg::WORD_W-1:0]     val_o,
  output logic                          occ_o,
  output logic [dq_pkg::WORD_W-1:0]     tap_o
);

  logic [dq_pkg::WORD_W-1:0] val_q, val_d;
  logic                      occ_q, occ_d;

  always_comb begin
    val_d = val_q;
    occ_d = occ_q;
    case (cmd_i.op)
      dq_pkg::CELL_SHIFT_UP: begin
        val_d = prev_val_i;
        occ_d = prev_occ_i;
      end
      dq_pkg::CELL_SHIFT_DN: begin
        val_d = next_val_i;
        occ_d = next_occ_i;
      end
      dq_pkg::CELL_PUSH_REAR: begin
        // first free cell after the occupied run takes the value
        if (!occ_q && prev_occ_i) begin
          val_d = cmd_i.value;
          occ_d = 1'b1;
        end
      end
      dq_pkg::CELL_DROP_REAR: begin
        if (occ_q && !next_occ_i) begin
          occ_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;
  assign occ_o = occ_q;
  // nonzero only in the last occupied cell
  assign tap_o = (occ_q && !next_occ_i) ? val_q : '0;

endmodule

>>> design/dq_rtree.sv
module dq_rtree #(
  parameter int unsigned N = dq_pkg::DEPTH,
  parameter int unsigned W = dq_pkg::WORD_W
) (
  input  logic          clk_i,
  input  logic [W-1:0]  tap_i [N],
  output logic [W-1:0]  sel_o
);

  localparam int unsigned LEVELS = dq_pkg::tree_levels(N);

  logic [W-1:0] lvl_q [LEVELS][N];
  logic [W-1:0] lvl_d [LEVELS][N];

  always_comb begin
    for (int l = 0; l < LEVELS; l++) begin
      for (int j = 0; j < N; j++) begin
        lvl_d[l][j] = '0;
        for (int k = 0; k < dq_pkg::FAN_IN; k++) begin
          if (j * dq_pkg::FAN_IN + k < N) begin
            if (l == 0) begin
              lvl_d[l][j] = lvl_d[l][j] | tap_i[j * dq_pkg::FAN_IN + k];
            end else begin
              lvl_d[l][j] = lvl_d[l][j] | lvl_q[l-1][j * dq_pkg::FAN_IN + k];
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lvl_q <= lvl_d;
  end

  assign sel_o = lvl_q[LEVELS-1][0];

endmodule
